// ----- rtl/mtf_pkg.sv -----
// Package: shared constants and types for the trial-factoring block.
`timescale 1ns / 1ps
package mtf_pkg;
  localparam int EXPONENT_BITS = 63;
  localparam int MULT_BITS = 64;
  localparam int Q_BITS = 128;
  localparam int EXP_CNT_BITS = $clog2(EXPONENT_BITS);
  localparam int BIT_CNT_BITS = $clog2(Q_BITS);

  typedef logic [Q_BITS-1:0] q_t;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DOUBLE
  } op_t;
endpackage

// ----- rtl/mtf_modmul.sv -----
// Shared modular unit: bit-serial a*a mod q (square), or a single 2a mod q step.
`timescale 1ns / 1ps
module mtf_modmul (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  mtf_pkg::op_t   op,
  input  mtf_pkg::q_t    a,
  input  mtf_pkg::q_t    q,
  output logic           done,
  output mtf_pkg::q_t    r
);
  import mtf_pkg::*;

  logic                    busy;
  op_t                     op_r;
  q_t                      b;
  logic [BIT_CNT_BITS-1:0] cnt;
  logic [Q_BITS:0]         dbl, dsub, add, asub;
  q_t                      r_dbl, r_add, r_step;

  // one modular add: doubling, then optional add of a
  always_comb begin
    dbl   = {r, 1'b0};
    dsub  = dbl - {1'b0, q};
    r_dbl = dsub[Q_BITS] ? dbl[Q_BITS-1:0] : dsub[Q_BITS-1:0];
    add   = {1'b0, r_dbl} + {1'b0, a};
    asub  = add - {1'b0, q};
    r_add = asub[Q_BITS] ? add[Q_BITS-1:0] : asub[Q_BITS-1:0];
    r_step = b[Q_BITS-1] ? r_add : r_dbl;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      op_r <= op;
      cnt  <= '1;
      if (op == OP_DOUBLE) begin
        r <= a;
      end else begin
        r <= '0;
      end
      b <= a;
    end else if (busy) begin
      if (op_r == OP_DOUBLE) begin
        r    <= r_dbl;
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        r   <= r_step;
        b   <= {b[Q_BITS-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/mersenne_trial_factor_test.sv -----
// Top level: exponent register, candidate formation and square-and-double sequencer.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  in       | in_valid / in_stall    | multiplier[63:0]
//  out      | out_valid / out_stall  | factor_found, candidate_low, candidate_high
//  config   | cfg_write              | cfg_data[62:0] (exponent)
//
// An item is accepted, then q is formed by shift-and-add, one step per exponent bit up to
// its top set bit; then for each of the 63 bits comes a bit-serial modular square, plus
// a doubling where the bit is set.
// Reset clears control state only; exponent returns to 1.
// The result is held until out_stall drops; in_stall is high while busy.
`timescale 1ns / 1ps
module mersenne_trial_factor_test (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [mtf_pkg::EXPONENT_BITS-1:0]  cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mtf_pkg::MULT_BITS-1:0]      multiplier,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               factor_found,
  output logic [63:0]                        candidate_low,
  output logic [63:0]                        candidate_high
);
  import mtf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PROD, S_SQ_GO, S_SQ_WAIT, S_DB_WAIT, S_OUT
  } state_t;

  state_t                  state;
  logic [EXPONENT_BITS-1:0] exponent;
  logic [EXPONENT_BITS-1:0] p_sh;
  q_t                      k_sh;
  q_t                      q, s;
  logic [EXP_CNT_BITS-1:0] bidx;
  logic                    u_start, u_done;
  op_t                     u_op;
  q_t                      u_a, u_r;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign candidate_low = q[63:0];
  assign candidate_high = q[127:64];

  mtf_modmul u_mod (
    .clk(clk), .rst(rst), .start(u_start), .op(u_op), .a(u_a), .q(q),
    .done(u_done), .r(u_r)
  );

  always_comb begin
    u_start = 1'b0;
    u_op = OP_MUL;
    if (state == S_SQ_GO) begin
      u_start = 1'b1;
    end else if (state == S_SQ_WAIT && u_done && exponent[bidx]) begin
      u_start = 1'b1;
      u_op = OP_DOUBLE;
    end
    // hold the square operand steady while the multiply runs
    u_a = (u_op == OP_DOUBLE) ? u_r : s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      exponent <= {{(EXPONENT_BITS-1){1'b0}}, 1'b1};
    end else begin
      if (cfg_write) begin
        exponent <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            k_sh  <= Q_BITS'({multiplier, 1'b0});
            p_sh  <= exponent;
            q     <= Q_BITS'(1);
            state <= S_PROD;
          end
        end
        S_PROD: begin
          // q = 2pk + 1 by shift-and-add over the exponent bits
          if (p_sh[0]) begin
            q <= q + k_sh;
          end
          k_sh <= {k_sh[Q_BITS-2:0], 1'b0};
          p_sh <= {1'b0, p_sh[EXPONENT_BITS-1:1]};
          if (p_sh[EXPONENT_BITS-1:1] == '0) begin
            bidx  <= EXP_CNT_BITS'(EXPONENT_BITS - 1);
            s     <= Q_BITS'(1);
            state <= S_SQ_GO;
          end
        end
        S_SQ_GO: begin
          if (q == Q_BITS'(1)) begin
            s <= '0;
          end
          state <= S_SQ_WAIT;
        end
        S_SQ_WAIT: begin
          if (u_done) begin
            s <= u_r;
            if (exponent[bidx]) begin
              state <= S_DB_WAIT;
            end else if (bidx == '0) begin
              state <= S_OUT;
            end else begin
              bidx  <= bidx - 1'b1;
              state <= S_SQ_GO;
            end
          end
        end
        S_DB_WAIT: begin
          if (u_done) begin
            s <= u_r;
            if (bidx == '0) begin
              state <= S_OUT;
            end else begin
              bidx  <= bidx - 1'b1;
              state <= S_SQ_GO;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign factor_found = (s == Q_BITS'(1));

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(q) && $stable(s)))
    else $error("result changed under stall");
  a_no_out_on_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");
endmodule
